>>> sv/bse_pkg.sv
// Shared constants, the OCV curve and the controller/datapath command types
// for the battery state-of-charge estimator. No dependencies.
package bse_pkg;

	localparam int BURST_LENGTH = 16;
	localparam int TABLE_POINTS = 12;

	localparam int RAW_W   = 12;
	localparam int CNT_W   = $clog2(BURST_LENGTH + 1);
	localparam int SUM_W   = RAW_W + $clog2(BURST_LENGTH);
	localparam int RATIO_W = 4;
	localparam int ALPHA_W = 16;
	localparam int CFG_W   = 16;
	localparam int IDX_W   = 2;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_ADC_READY = 2'd0;
	localparam logic [IDX_W-1:0] REG_ALPHA     = 2'd1;
	localparam logic [IDX_W-1:0] REG_RATIO     = 2'd2;

	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd19661;
	localparam logic [RATIO_W-1:0] RATIO_RESET = 4'd2;

	// Shared restoring divider.
	localparam int DIV_W  = 24;
	localparam int DVS_W  = 12;
	localparam int STEP_W = $clog2(DIV_W);

	localparam logic [DVS_W-1:0] ADC_FULL   = 12'd4095;
	localparam logic [RAW_W-1:0] VREF_MV    = 12'd3300;

	localparam int VBAT_W = RAW_W + RATIO_W;
	localparam int MV_W   = 13;
	localparam int PCT_W  = 7;
	localparam int FRAC_W = 16;
	localparam int S_W    = PCT_W + FRAC_W;
	localparam int SEG_W  = $clog2(TABLE_POINTS);

	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
	localparam logic [S_W-1:0]   S_MAX   = {PCT_MAX, {FRAC_W{1'b0}}};

	localparam logic [MV_W-1:0] OCV_MV [TABLE_POINTS] = '{
		13'd4200, 13'd4060, 13'd3980, 13'd3920, 13'd3870, 13'd3820,
		13'd3790, 13'd3770, 13'd3740, 13'd3680, 13'd3450, 13'd3300
	};
	localparam logic [PCT_W-1:0] OCV_PCT [TABLE_POINTS] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
		7'd40,  7'd30, 7'd20, 7'd10, 7'd5,  7'd0
	};

	// Datapath operations.
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
	localparam logic [OP_W-1:0] OP_AVG_LD   = 4'd1;
	localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd2;
	localparam logic [OP_W-1:0] OP_MV_LD    = 4'd3;
	localparam logic [OP_W-1:0] OP_VBAT     = 4'd4;
	localparam logic [OP_W-1:0] OP_SEG      = 4'd5;
	localparam logic [OP_W-1:0] OP_PCT      = 4'd6;
	localparam logic [OP_W-1:0] OP_EMA_MUL  = 4'd7;
	localparam logic [OP_W-1:0] OP_EMA_ACC  = 4'd8;
	localparam logic [OP_W-1:0] OP_OUT_LD   = 4'd9;
	localparam logic [OP_W-1:0] OP_MV_DIV   = 4'd10;

	typedef struct packed {
		logic            acc;
		logic            clr;
		logic            fresh;
		logic [OP_W-1:0] op;
	} dp_cmd_t;

	typedef struct packed {
		logic adc_ready;
		logic burst_end;
		logic no_good;
		logic div_last;
		logic vbat_mid;
	} dp_stat_t;

endpackage

>>> sv/bse_dp.sv
// Datapath of the estimator: configuration registers, burst accumulator,
// shared 24-step divider, OCV interpolation, moving average and result register.
// Depends on bse_pkg.
module bse_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [bse_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bse_pkg::CFG_W-1:0]    cfg_data,
	input  logic [bse_pkg::RAW_W-1:0]    raw_sample,
	input  logic                         read_ok,
	input  bse_pkg::dp_cmd_t             cmd,
	output bse_pkg::dp_stat_t            stat,
	output logic signed [7:0]            percent,
	output logic                         fresh_reading
);

	logic                          adc_ready_q;
	logic [bse_pkg::ALPHA_W-1:0]   alpha_q;
	logic [bse_pkg::RATIO_W-1:0]   ratio_q;

	logic [bse_pkg::SUM_W-1:0]     sum_q;
	logic [bse_pkg::CNT_W-1:0]     good_q;
	logic [bse_pkg::CNT_W-1:0]     attempt_q;

	logic [bse_pkg::DIV_W-1:0]     dq_q;
	logic [bse_pkg::DVS_W-1:0]     rem_q;
	logic [bse_pkg::DVS_W-1:0]     dvs_q;
	logic [bse_pkg::STEP_W-1:0]    step_q;

	logic [bse_pkg::VBAT_W-1:0]    vbat_q;
	logic [bse_pkg::PCT_W-1:0]     pct_q;
	logic signed [40:0]            prod_q;
	logic [bse_pkg::S_W-1:0]       s_q;
	logic                          seeded_q;
	logic signed [7:0]             percent_q;
	logic                          fresh_q;

	// Divider step.
	logic [bse_pkg::DVS_W:0]       trial;
	logic                          trial_ge;
	logic [bse_pkg::DVS_W:0]       trial_sub;

	// Scaling to millivolts and battery voltage.
	logic [bse_pkg::DIV_W-1:0]     mv_prod;
	logic [bse_pkg::VBAT_W-1:0]    vbat_prod;

	// Division by full scale: the top bits give a quotient that is at most one short.
	logic [bse_pkg::DVS_W-1:0]     mv_est;
	logic [bse_pkg::DVS_W:0]       mv_rem;
	logic                          mv_carry;
	logic [bse_pkg::DVS_W-1:0]     mv_div;

	// Segment search and interpolation terms.
	logic                          seg_found;
	logic [bse_pkg::SEG_W-1:0]     seg_hi;
	logic [bse_pkg::SEG_W-1:0]     seg_lo;
	logic [bse_pkg::MV_W-1:0]      hi_mv;
	logic [bse_pkg::MV_W-1:0]      lo_mv;
	logic [bse_pkg::MV_W-1:0]      dm;
	logic [bse_pkg::PCT_W-1:0]     dp_pct;
	logic [bse_pkg::MV_W-1:0]      off_mv;
	logic [bse_pkg::DIV_W-1:0]     interp_num;
	logic                          vbat_top;
	logic                          vbat_bottom;

	// Moving average.
	logic [bse_pkg::S_W-1:0]       target;
	logic signed [23:0]            diff;
	logic signed [40:0]            prod_rnd;
	logic signed [25:0]            s_sum;
	logic [bse_pkg::S_W:0]         s_rnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adc_ready_q <= 1'b1;
			alpha_q     <= bse_pkg::ALPHA_RESET;
			ratio_q     <= bse_pkg::RATIO_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bse_pkg::REG_ADC_READY: adc_ready_q <= cfg_data[0];
				bse_pkg::REG_ALPHA:     alpha_q     <= cfg_data[bse_pkg::ALPHA_W-1:0];
				bse_pkg::REG_RATIO:     ratio_q     <= cfg_data[bse_pkg::RATIO_W-1:0];
				default: ;
			endcase
		end
	end

	// Burst accumulator; a clear takes precedence over a new request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			good_q    <= '0;
			attempt_q <= '0;
		end else if (cmd.clr) begin
			sum_q     <= '0;
			good_q    <= '0;
			attempt_q <= '0;
		end else if (cmd.acc) begin
			attempt_q <= attempt_q + 1'b1;
			if (read_ok) begin
				sum_q  <= sum_q + bse_pkg::SUM_W'(raw_sample);
				good_q <= good_q + 1'b1;
			end
		end
	end

	assign trial     = {rem_q, dq_q[bse_pkg::DIV_W-1]};
	assign trial_ge  = trial >= {1'b0, dvs_q};
	assign trial_sub = trial - {1'b0, dvs_q};

	assign mv_prod   = {{(bse_pkg::DIV_W-bse_pkg::RAW_W){1'b0}}, dq_q[bse_pkg::RAW_W-1:0]}
		* {{(bse_pkg::DIV_W-bse_pkg::RAW_W){1'b0}}, bse_pkg::VREF_MV};
	assign vbat_prod = {{bse_pkg::RATIO_W{1'b0}}, dq_q[bse_pkg::RAW_W-1:0]}
		* {{bse_pkg::RAW_W{1'b0}}, ratio_q};

	assign mv_est   = dq_q[bse_pkg::DIV_W-1:bse_pkg::RAW_W];
	assign mv_rem   = {1'b0, dq_q[bse_pkg::RAW_W-1:0]} + {1'b0, mv_est};
	assign mv_carry = mv_rem >= {1'b0, bse_pkg::ADC_FULL};
	assign mv_div   = mv_est + {{(bse_pkg::DVS_W-1){1'b0}}, mv_carry};

	assign vbat_top    = vbat_q >= bse_pkg::VBAT_W'(bse_pkg::OCV_MV[0]);
	assign vbat_bottom = vbat_q <= bse_pkg::VBAT_W'(bse_pkg::OCV_MV[bse_pkg::TABLE_POINTS-1]);

	// First segment whose end points enclose the voltage.
	always_comb begin
		seg_found = 1'b0;
		seg_hi    = '0;
		for (int i = 0; i < bse_pkg::TABLE_POINTS - 1; i++) begin
			if (!seg_found && vbat_q <= bse_pkg::VBAT_W'(bse_pkg::OCV_MV[i])
					&& vbat_q >= bse_pkg::VBAT_W'(bse_pkg::OCV_MV[i+1])) begin
				seg_found = 1'b1;
				seg_hi    = bse_pkg::SEG_W'(i);
			end
		end
	end

	assign seg_lo     = seg_hi + 1'b1;
	assign hi_mv      = bse_pkg::OCV_MV[seg_hi];
	assign lo_mv      = bse_pkg::OCV_MV[seg_lo];
	assign dm         = hi_mv - lo_mv;
	assign dp_pct     = bse_pkg::OCV_PCT[seg_hi] - bse_pkg::OCV_PCT[seg_lo];
	assign off_mv     = bse_pkg::MV_W'(vbat_q) - lo_mv;
	assign interp_num = (bse_pkg::DIV_W'(off_mv) * bse_pkg::DIV_W'(dp_pct) << 1)
		+ bse_pkg::DIV_W'(dm);

	assign target   = {pct_q, {bse_pkg::FRAC_W{1'b0}}};
	assign diff     = $signed({1'b0, target}) - $signed({1'b0, s_q});
	assign prod_rnd = prod_q + 41'sd32768;
	assign s_sum    = $signed({3'b000, s_q}) + {prod_rnd[40], prod_rnd[40:16]};
	assign s_rnd    = {1'b0, s_q} + 24'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seeded_q <= 1'b0;
			s_q      <= '0;
		end else if (cmd.op == bse_pkg::OP_EMA_ACC) begin
			seeded_q <= 1'b1;
			if (!seeded_q) begin
				s_q <= target;
			end else if (s_sum < 0) begin
				s_q <= '0;
			end else if (s_sum > $signed({3'b000, bse_pkg::S_MAX})) begin
				s_q <= bse_pkg::S_MAX;
			end else begin
				s_q <= s_sum[bse_pkg::S_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bse_pkg::OP_AVG_LD: begin
				dq_q   <= bse_pkg::DIV_W'(sum_q);
				dvs_q  <= bse_pkg::DVS_W'(good_q);
				rem_q  <= '0;
				step_q <= '0;
			end
			bse_pkg::OP_DIV_STEP: begin
				dq_q   <= {dq_q[bse_pkg::DIV_W-2:0], trial_ge};
				rem_q  <= trial_ge ? trial_sub[bse_pkg::DVS_W-1:0] : trial[bse_pkg::DVS_W-1:0];
				step_q <= step_q + 1'b1;
			end
			bse_pkg::OP_MV_LD: begin
				dq_q   <= mv_prod;
			end
			bse_pkg::OP_MV_DIV: begin
				dq_q   <= {{(bse_pkg::DIV_W-bse_pkg::DVS_W){1'b0}}, mv_div};
			end
			bse_pkg::OP_VBAT: begin
				vbat_q <= vbat_prod;
			end
			bse_pkg::OP_SEG: begin
				if (vbat_top) begin
					pct_q <= bse_pkg::PCT_MAX;
				end else if (vbat_bottom) begin
					pct_q <= '0;
				end else begin
					pct_q  <= bse_pkg::OCV_PCT[seg_lo];
					dq_q   <= interp_num;
					dvs_q  <= bse_pkg::DVS_W'({dm, 1'b0});
					rem_q  <= '0;
					step_q <= '0;
				end
			end
			bse_pkg::OP_PCT: begin
				pct_q <= pct_q + dq_q[bse_pkg::PCT_W-1:0];
			end
			bse_pkg::OP_EMA_MUL: begin
				prod_q <= $signed({1'b0, alpha_q}) * diff;
			end
			bse_pkg::OP_OUT_LD: begin
				percent_q <= seeded_q ? $signed(s_rnd[bse_pkg::S_W:bse_pkg::FRAC_W]) : -8'sd1;
				fresh_q   <= cmd.fresh;
			end
			default: ;
		endcase
	end

	assign stat.adc_ready = adc_ready_q;
	assign stat.burst_end = attempt_q == bse_pkg::CNT_W'(bse_pkg::BURST_LENGTH - 1);
	assign stat.no_good   = (good_q == '0) && !read_ok;
	assign stat.div_last  = step_q == bse_pkg::STEP_W'(bse_pkg::DIV_W - 1);
	assign stat.vbat_mid  = !vbat_top && !vbat_bottom;

	assign percent       = percent_q;
	assign fresh_reading = fresh_q;

endmodule

>>> sv/bse_ctrl.sv
// Controller of the estimator: sequences accumulation, the average and interpolation
// divisions, scaling, smoothing, and owns both handshakes. Depends on bse_pkg.
module bse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  bse_pkg::dp_stat_t  stat,
	output bse_pkg::dp_cmd_t   cmd
);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_AVG_LD  = 4'd1;
	localparam logic [3:0] S_AVG_DIV = 4'd2;
	localparam logic [3:0] S_MV_LD   = 4'd3;
	localparam logic [3:0] S_MV_DIV  = 4'd4;
	localparam logic [3:0] S_VBAT    = 4'd5;
	localparam logic [3:0] S_SEG     = 4'd6;
	localparam logic [3:0] S_INT_DIV = 4'd7;
	localparam logic [3:0] S_PCT     = 4'd8;
	localparam logic [3:0] S_EMA_MUL = 4'd9;
	localparam logic [3:0] S_EMA_ACC = 4'd10;
	localparam logic [3:0] S_OUT     = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       fresh_q;
	logic       fresh_d;
	logic       out_valid_q;
	logic       out_load;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_load  = cmd.op == bse_pkg::OP_OUT_LD;

	always_comb begin
		state_d   = state_q;
		fresh_d   = fresh_q;
		cmd.acc   = 1'b0;
		cmd.clr   = 1'b0;
		cmd.fresh = fresh_q;
		cmd.op    = bse_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (!stat.adc_ready) begin
						// A converter that is not ready drops the partial burst.
						cmd.clr = 1'b1;
						fresh_d = 1'b0;
						state_d = S_OUT;
					end else if (stat.burst_end && stat.no_good) begin
						cmd.clr = 1'b1;
						fresh_d = 1'b0;
						state_d = S_OUT;
					end else begin
						cmd.acc = 1'b1;
						if (stat.burst_end) begin
							fresh_d = 1'b1;
							state_d = S_AVG_LD;
						end
					end
				end
			end
			S_AVG_LD: begin
				cmd.op  = bse_pkg::OP_AVG_LD;
				cmd.clr = 1'b1;
				state_d = S_AVG_DIV;
			end
			S_AVG_DIV: begin
				cmd.op = bse_pkg::OP_DIV_STEP;
				if (stat.div_last) begin
					state_d = S_MV_LD;
				end
			end
			S_MV_LD: begin
				cmd.op  = bse_pkg::OP_MV_LD;
				state_d = S_MV_DIV;
			end
			S_MV_DIV: begin
				cmd.op  = bse_pkg::OP_MV_DIV;
				state_d = S_VBAT;
			end
			S_VBAT: begin
				cmd.op  = bse_pkg::OP_VBAT;
				state_d = S_SEG;
			end
			S_SEG: begin
				cmd.op  = bse_pkg::OP_SEG;
				state_d = stat.vbat_mid ? S_INT_DIV : S_EMA_MUL;
			end
			S_INT_DIV: begin
				cmd.op = bse_pkg::OP_DIV_STEP;
				if (stat.div_last) begin
					state_d = S_PCT;
				end
			end
			S_PCT: begin
				cmd.op  = bse_pkg::OP_PCT;
				state_d = S_EMA_MUL;
			end
			S_EMA_MUL: begin
				cmd.op  = bse_pkg::OP_EMA_MUL;
				state_d = S_EMA_ACC;
			end
			S_EMA_ACC: begin
				cmd.op  = bse_pkg::OP_EMA_ACC;
				state_d = S_OUT;
			end
			S_OUT: begin
				// The result register is loaded once the previous result has been taken, or is being taken.
				if (!out_valid_q || out_ready) begin
					cmd.op  = bse_pkg::OP_OUT_LD;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fresh_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fresh_q <= fresh_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/battery_soc_estimator_unit.sv
// Battery state-of-charge estimator: top level joining controller and datapath.
// Depends on bse_pkg, bse_ctrl and bse_dp.
// A request inside a burst is taken while idle. A request closing a burst with a good
// read runs average load, a shared 24-step divider pass, mV scaling, battery voltage,
// segment search, an interpolation divider pass, percent sum, smoothing and output load;
// off either end of the curve the interpolation steps are skipped. No new request is
// taken meanwhile. A closing burst without a good read, or a converter not ready, goes
// straight to the output state; a result waiting at the output delays the next one.
// Asynchronous reset restores configuration, burst and smoothing state; output empties.
module battery_soc_estimator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [bse_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bse_pkg::CFG_W-1:0]    cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [bse_pkg::RAW_W-1:0]    raw_sample,
	input  logic                         read_ok,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [7:0]            percent,
	output logic                         fresh_reading
);

	bse_pkg::dp_cmd_t  cmd;
	bse_pkg::dp_stat_t stat;

	bse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bse_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.raw_sample    (raw_sample),
		.read_ok       (read_ok),
		.cmd           (cmd),
		.stat          (stat),
		.percent       (percent),
		.fresh_reading (fresh_reading)
	);

endmodule
